// ===== rtl/core/pdsa_pkg.sv =====
// ============================================================================
// pdsa_pkg
// Types, codes and fixed response frames of the PD sink auto-responder.
// ============================================================================
package pdsa_pkg;

  // Input item: received frame or millisecond tick
  typedef struct packed {
    logic       kind;
    logic       is_sop0;
    logic [5:0] frame_len;
    logic [7:0] hdr_lo;
    logic [7:0] hdr_hi;
    logic [7:0] pay0;
    logic [7:0] pay1;
    logic [7:0] pay2;
    logic [7:0] pay3;
    logic       tx_ready;
  } pdsa_in_t;

  // Result item: one byte of a response frame
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } pdsa_out_t;

  // Response frame codes
  typedef logic [2:0] pdsa_code_t;
  localparam pdsa_code_t CODE_REQUEST   = 3'd0;
  localparam pdsa_code_t CODE_SINK_CAP  = 3'd1;
  localparam pdsa_code_t CODE_ACCEPT    = 3'd2;
  localparam pdsa_code_t CODE_KEEPALIVE = 3'd3;
  localparam pdsa_code_t CODE_CHUNK_REQ = 3'd4;
  localparam pdsa_code_t CODE_EPR_REQ   = 3'd5;

  // Response descriptor passed from front to back
  typedef struct packed {
    pdsa_code_t code;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
  } pdsa_desc_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_PD_ENABLED = 2'd0;
  localparam logic [1:0] CFG_SPEC_REV   = 2'd1;
  localparam logic [1:0] CFG_KA_PERIOD  = 2'd2;

  localparam logic [1:0]  SPEC_REV_30       = 2'd3;
  localparam logic [1:0]  SPEC_REV_RESET    = 2'd2;
  localparam logic [15:0] KA_PERIOD_RESET   = 16'd500;
  localparam logic [5:0]  MIN_FRAME_LEN     = 6'd6;
  localparam logic [4:0]  MSG_SRC_CAP       = 5'h01;
  localparam logic [4:0]  MSG_PS_RDY        = 5'h06;
  localparam logic [4:0]  MSG_GET_SINK_CAP  = 5'h08;
  localparam logic [4:0]  MSG_SOFT_RESET    = 5'h0D;
  localparam logic [4:0]  MSG_EXT_CONTROL   = 5'h10;
  localparam logic [4:0]  MSG_EPR_SRC_CAP   = 5'h11;
  localparam logic [7:0]  ECDB_KEEPALIVE_ACK = 8'h04;
  localparam logic [8:0]  EXT_SIZE_MIN      = 9'd2;

  // Number of bytes in a response frame
  function automatic logic [3:0] frame_len(input pdsa_code_t code);
    logic [3:0] n;
    unique case (code)
      CODE_REQUEST:   n = 4'd6;
      CODE_SINK_CAP:  n = 4'd10;
      CODE_ACCEPT:    n = 4'd2;
      CODE_KEEPALIVE: n = 4'd6;
      CODE_CHUNK_REQ: n = 4'd6;
      CODE_EPR_REQ:   n = 4'd10;
      default:        n = 4'd2;
    endcase
    return n;
  endfunction

  // Byte idx of the response frame described by d
  function automatic logic [7:0] frame_byte(input pdsa_desc_t d, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (d.code)
      CODE_REQUEST: begin
        case (idx)
          4'd0:    b = 8'h42;
          4'd1:    b = 8'h10;
          4'd2:    b = d.r0;
          4'd3:    b = d.r1;
          4'd4:    b = d.r2;
          default: b = 8'h13;
        endcase
      end
      CODE_SINK_CAP: begin
        case (idx)
          4'd0:    b = 8'h04;
          4'd1:    b = 8'h20;
          4'd2:    b = 8'h0A;
          4'd3:    b = 8'h90;
          4'd4:    b = 8'h01;
          4'd5:    b = 8'h00;
          4'd6:    b = 8'h3C;
          4'd7:    b = 8'h21;
          4'd8:    b = 8'hDC;
          default: b = 8'hC0;
        endcase
      end
      CODE_ACCEPT: begin
        b = (idx == 4'd0) ? 8'h03 : 8'h00;
      end
      CODE_KEEPALIVE: begin
        case (idx)
          4'd0:    b = 8'h10;
          4'd1:    b = 8'h90;
          4'd2:    b = 8'h02;
          4'd3:    b = 8'h80;
          4'd4:    b = 8'h03;
          default: b = 8'h00;
        endcase
      end
      CODE_CHUNK_REQ: begin
        case (idx)
          4'd0:    b = 8'h11;
          4'd1:    b = 8'h90;
          4'd3:    b = 8'h8C;
          default: b = 8'h00;
        endcase
      end
      CODE_EPR_REQ: begin
        case (idx)
          4'd0:    b = 8'h09;
          4'd1:    b = 8'h20;
          4'd2:    b = 8'h2C;
          4'd3:    b = 8'hB1;
          4'd4:    b = 8'h44;
          4'd5:    b = 8'h13;
          4'd6:    b = 8'h2C;
          4'd7:    b = 8'h91;
          4'd8:    b = 8'h81;
          default: b = 8'h0A;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/pdsa_front.sv =====
// ============================================================================
// pdsa_front
// Accepts frames and ticks, holds configuration and EPR state, and
// pushes a descriptor of each response frame into the command queue.
// ============================================================================
module pdsa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  pdsa_pkg::pdsa_in_t   in_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata,
  output logic                 q_push,
  output pdsa_pkg::pdsa_desc_t q_desc
);

  logic        pd_enabled_r;
  logic [1:0]  spec_rev_r;
  logic [15:0] ka_period_r;

  logic        epr_req_sent_r, epr_req_sent_nxt;
  logic        epr_active_r, epr_active_nxt;
  logic        ka_armed_r, ka_armed_nxt;
  logic [15:0] ka_remain_r, ka_remain_nxt;

  logic        rev30;
  logic        frame_ok;
  logic [4:0]  msg_type;
  logic        ext;
  logic [15:0] ehdr;
  logic [15:0] ka_dec;
  logic [7:0]  r1;
  logic [7:0]  r2;

  assign rev30    = (spec_rev_r == pdsa_pkg::SPEC_REV_30);
  assign msg_type = in_item.hdr_lo[4:0];
  assign ext      = in_item.hdr_hi[7];
  assign ehdr     = {in_item.pay1, in_item.pay0};
  assign frame_ok = pd_enabled_r && in_item.is_sop0 &&
                    (in_item.frame_len >= pdsa_pkg::MIN_FRAME_LEN);
  assign ka_dec   = (ka_remain_r != 16'd0) ? ka_remain_r - 16'd1 : 16'd0;

  // Request data object bytes derived from the first source PDO
  assign r1 = {in_item.pay0[5:0], in_item.pay1[1:0]};
  always_comb begin
    r2 = {4'b0000, r1[1:0], in_item.pay0[7:6]};
    if (rev30) begin
      r2[7] = in_item.pay3[0];
      r2[6] = in_item.pay2[7];
    end
  end

  always_comb begin
    epr_req_sent_nxt = epr_req_sent_r;
    epr_active_nxt   = epr_active_r;
    ka_armed_nxt     = ka_armed_r;
    ka_remain_nxt    = ka_remain_r;
    q_push           = 1'b0;
    q_desc.code      = pdsa_pkg::CODE_REQUEST;
    q_desc.r0        = in_item.pay0;
    q_desc.r1        = r1;
    q_desc.r2        = r2;
    if (accept) begin
      if (in_item.kind) begin
        if (epr_active_r && ka_armed_r) begin
          ka_remain_nxt = ka_dec;
          if (ka_dec == 16'd0 && rev30 && in_item.tx_ready) begin
            ka_remain_nxt = ka_period_r;
            q_push        = 1'b1;
            q_desc.code   = pdsa_pkg::CODE_KEEPALIVE;
          end
        end
      end else if (frame_ok) begin
        if (!ext) begin
          unique case (msg_type)
            pdsa_pkg::MSG_SRC_CAP: begin
              if (in_item.hdr_hi[6:4] != 3'd0) begin
                q_push      = 1'b1;
                q_desc.code = pdsa_pkg::CODE_REQUEST;
              end
            end
            pdsa_pkg::MSG_GET_SINK_CAP: begin
              q_push      = 1'b1;
              q_desc.code = pdsa_pkg::CODE_SINK_CAP;
            end
            pdsa_pkg::MSG_SOFT_RESET: begin
              epr_req_sent_nxt = 1'b0;
              epr_active_nxt   = 1'b0;
              ka_armed_nxt     = 1'b0;
              ka_remain_nxt    = 16'd0;
              q_push           = 1'b1;
              q_desc.code      = pdsa_pkg::CODE_ACCEPT;
            end
            pdsa_pkg::MSG_PS_RDY: begin
              if (rev30 && epr_req_sent_r) begin
                epr_active_nxt = 1'b1;
                ka_armed_nxt   = 1'b1;
                ka_remain_nxt  = ka_period_r;
                q_push         = 1'b1;
                q_desc.code    = pdsa_pkg::CODE_KEEPALIVE;
              end
            end
            default: ;
          endcase
        end else if (rev30) begin
          unique case (msg_type)
            pdsa_pkg::MSG_EPR_SRC_CAP: begin
              // chunked, not a chunk request
              if (ehdr[15] && !ehdr[10]) begin
                if (ehdr[14:11] == 4'd0) begin
                  q_push      = 1'b1;
                  q_desc.code = pdsa_pkg::CODE_CHUNK_REQ;
                end else if (ehdr[14:11] == 4'd1) begin
                  epr_req_sent_nxt = 1'b1;
                  q_push           = 1'b1;
                  q_desc.code      = pdsa_pkg::CODE_EPR_REQ;
                end
              end
            end
            pdsa_pkg::MSG_EXT_CONTROL: begin
              if (ehdr[8:0] >= pdsa_pkg::EXT_SIZE_MIN &&
                  in_item.pay2 == pdsa_pkg::ECDB_KEEPALIVE_ACK) begin
                epr_active_nxt = 1'b1;
                ka_armed_nxt   = 1'b1;
                ka_remain_nxt  = ka_period_r;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_enabled_r   <= 1'b0;
      spec_rev_r     <= pdsa_pkg::SPEC_REV_RESET;
      ka_period_r    <= pdsa_pkg::KA_PERIOD_RESET;
      epr_req_sent_r <= 1'b0;
      epr_active_r   <= 1'b0;
      ka_armed_r     <= 1'b0;
      ka_remain_r    <= 16'd0;
    end else begin
      epr_req_sent_r <= epr_req_sent_nxt;
      epr_active_r   <= epr_active_nxt;
      ka_armed_r     <= ka_armed_nxt;
      ka_remain_r    <= ka_remain_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pdsa_pkg::CFG_PD_ENABLED: pd_enabled_r <= cfg_wdata[0];
          pdsa_pkg::CFG_SPEC_REV:   spec_rev_r   <= cfg_wdata[1:0];
          pdsa_pkg::CFG_KA_PERIOD:  ka_period_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/pdsa_cmd_queue.sv =====
// ============================================================================
// pdsa_cmd_queue
// Short queue of response descriptors between front and back.
// ============================================================================
module pdsa_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pdsa_pkg::pdsa_desc_t push_desc,
  input  logic                 pop,
  output pdsa_pkg::pdsa_desc_t pop_desc,
  output logic                 q_full,
  output logic                 q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pdsa_pkg::pdsa_desc_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign q_full   = (count_r == CW'(DEPTH));
  assign q_empty  = (count_r == '0);
  assign do_push  = push && !q_full;
  assign do_pop   = pop && !q_empty;
  assign pop_desc = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/pdsa_back.sv =====
// ============================================================================
// pdsa_back
// Serialises one response frame per descriptor into an output register.
// ============================================================================
module pdsa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  pdsa_pkg::pdsa_desc_t q_desc,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output pdsa_pkg::pdsa_out_t  out_data
);

  pdsa_pkg::pdsa_desc_t cur_r;
  logic [3:0]           idx_r;
  logic                 busy_r;
  pdsa_pkg::pdsa_out_t  out_r;
  logic                 out_vld_r;
  logic                 adv;
  logic                 is_last;

  assign adv      = !out_vld_r || pop;
  assign q_pop    = !busy_r && !q_empty;
  assign is_last  = (idx_r == pdsa_pkg::frame_len(cur_r.code) - 4'd1);
  assign empty    = !out_vld_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
    if (adv && busy_r) begin
      out_r.out_byte <= pdsa_pkg::frame_byte(cur_r, idx_r);
      out_r.last     <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      idx_r     <= 4'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= 4'd0;
      end else if (adv && busy_r) begin
        idx_r <= idx_r + 4'd1;
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end
      if (adv) begin
        out_vld_r <= busy_r;
      end
    end
  end

endmodule

// ===== rtl/core/pd_sink_auto_responder.sv =====
// ============================================================================
// pd_sink_auto_responder
// USB PD sink auto-responder: answers received SOP frames and millisecond
// ticks with response frames, emitted one byte per transfer.
// ============================================================================
//
//  channel   ports                              transfer when
//  --------  ---------------------------------  --------------------------
//  input     push, full, in_data                push && !full
//  result    empty, pop, out_data               pop && !empty
//  config    cfg_we, cfg_index, cfg_wdata       cfg_we (no wait)
//
// An item is taken in every cycle while the command queue has room; the
// front classifies it and updates the EPR state in that same cycle.
// A response frame leaves at one byte per cycle while pop is not stalled,
// from the output register; between frames the output runs empty while
// the back loads the next descriptor.
// Reset is synchronous and active low: queue and output register empty,
// EPR state cleared, registers at their reset values.
// A stalled pop holds the output byte; full rises only while QUEUE_DEPTH
// frames are still waiting behind it.
//
module pd_sink_auto_responder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  output logic                full,
  input  pdsa_pkg::pdsa_in_t  in_data,
  // result channel
  output logic                empty,
  input  logic                pop,
  output pdsa_pkg::pdsa_out_t out_data,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  logic                 accept;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_empty;
  pdsa_pkg::pdsa_desc_t push_desc;
  pdsa_pkg::pdsa_desc_t pop_desc;

  // Accept an item only while the queue can hold a possible response
  assign accept = push && !full;

  pdsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  // Decouple classification from serialisation
  pdsa_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_desc  (pop_desc),
    .q_full    (full),
    .q_empty   (q_empty)
  );

  // Drain descriptors byte by byte towards the result port
  pdsa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_desc   (pop_desc),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/pdsa_checker.sv =====
// ============================================================================
// pdsa_checker
// Port-level checks of the PD sink auto-responder, bound to the top level.
// ============================================================================
module pdsa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input pdsa_pkg::pdsa_out_t out_data
);

  logic [3:0] byte_cnt_r;

  // Count bytes of the frame in flight on the result port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= 4'd0;
    end else if (pop && !empty) begin
      byte_cnt_r <= out_data.last ? 4'd0 : byte_cnt_r + 4'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("result side not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("stalled result changed");

  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && !out_data.last |-> byte_cnt_r < 4'd9)
    else $error("response frame longer than ten bytes");

  a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
    !push |=> !$rose(full))
    else $error("full rose without a transfer");

endmodule

bind pd_sink_auto_responder pdsa_checker u_pdsa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

// ===== tb/sv/tb_pd_sink_auto_responder.sv =====
// ============================================================================
// tb_pd_sink_auto_responder
// Self-checking bench for the PD sink auto-responder. Received frames and
// millisecond ticks go in through the push/full queue port. An in-bench model
// of the sink policy predicts each response frame byte by byte at the moment
// the item transfers. Every byte popped from the block is checked against the
// oldest predicted byte. A short directed run covers each message and corner
// of the EPR handshake. Random phases under several register settings follow,
// with bursty input and a stalling receiver.
// ============================================================================
module tb_pd_sink_auto_responder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;

  // Fixed response frames, first byte in the top bits; short frames are
  // left-aligned and padded with zeros.
  localparam logic [79:0] SINK_CAP_FRAME  = 80'h04_20_0A_90_01_00_3C_21_DC_C0;
  localparam logic [79:0] EPR_REQ_FRAME   = 80'h09_20_2C_B1_44_13_2C_91_81_0A;
  localparam logic [79:0] KEEPALIVE_FRAME = {48'h10_90_02_80_03_00, 32'h0};
  localparam logic [79:0] CHUNK_REQ_FRAME = {48'h11_90_00_8C_00_00, 32'h0};
  localparam logic [79:0] ACCEPT_FRAME    = {16'h03_00, 64'h0};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  pdsa_pkg::pdsa_in_t  in_data = '0;
  logic                empty;
  logic                pop = 1'b0;
  pdsa_pkg::pdsa_out_t out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = pdsa_pkg::CFG_PD_ENABLED;
  logic [15:0]         cfg_wdata = '0;

  always #2 clk = ~clk;

  pd_sink_auto_responder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Sink policy model: a local copy of the registers and of the EPR state
  // --------------------------------------------------------------------------
  logic        en_sink   = 1'b0;
  logic [1:0]  rev_code  = pdsa_pkg::SPEC_REV_RESET;
  logic [15:0] ka_period = pdsa_pkg::KA_PERIOD_RESET;

  logic        epr_req_seen = 1'b0;
  logic        epr_mode     = 1'b0;
  logic        ka_armed     = 1'b0;
  logic [15:0] ka_count     = '0;

  pdsa_pkg::pdsa_in_t  frames_to_send[$];   // items waiting for the driver
  pdsa_pkg::pdsa_out_t bytes_due[$];        // predicted response bytes, oldest first

  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned errors       = 0;

  // Queue the first n bytes of a frame, marking the final one
  function automatic void expect_frame(input logic [79:0] bytes, input int n);
    pdsa_pkg::pdsa_out_t b;
    for (int k = 0; k < n; k++) begin
      b.out_byte = bytes[79 - 8*k -: 8];
      b.last     = (k == n - 1);
      bytes_due.push_back(b);
    end
  endfunction

  function automatic void arm_countdown();
    epr_mode = 1'b1;
    ka_armed = 1'b1;
    ka_count = ka_period;
  endfunction

  // Work out the response to one transferred item and update the EPR state
  function automatic void predict_response(input pdsa_pkg::pdsa_in_t it);
    logic       ext;
    logic [4:0] mtype;
    logic [7:0] r1;
    logic [7:0] r2;
    ext   = it.hdr_hi[7];
    mtype = it.hdr_lo[4:0];
    if (it.kind) begin
      // Tick: count down while EPR mode is armed; a KeepAlive that cannot go
      // out stays pending at zero until a ready tick comes along.
      if (epr_mode && ka_armed) begin
        if (ka_count != 16'd0) ka_count = ka_count - 16'd1;
        if (ka_count == 16'd0 && rev_code == pdsa_pkg::SPEC_REV_30 && it.tx_ready) begin
          ka_count = ka_period;
          expect_frame(KEEPALIVE_FRAME, 6);
        end
      end
    end else if (en_sink && it.is_sop0 && it.frame_len >= pdsa_pkg::MIN_FRAME_LEN) begin
      if (!ext) begin
        case (mtype)
          pdsa_pkg::MSG_SRC_CAP: if (it.hdr_hi[6:4] != 3'd0) begin
            // Request object derived from the first source PDO
            r1 = {it.pay0[5:0], it.pay1[1:0]};
            r2 = {4'h0, r1[1:0], it.pay0[7:6]};
            if (rev_code == pdsa_pkg::SPEC_REV_30) r2[7:6] = {it.pay3[0], it.pay2[7]};
            expect_frame({8'h42, 8'h10, it.pay0, r1, r2, 8'h13, 32'h0}, 6);
          end
          pdsa_pkg::MSG_GET_SINK_CAP: expect_frame(SINK_CAP_FRAME, 10);
          pdsa_pkg::MSG_SOFT_RESET: begin
            epr_req_seen = 1'b0;
            epr_mode     = 1'b0;
            ka_armed     = 1'b0;
            ka_count     = '0;
            expect_frame(ACCEPT_FRAME, 2);
          end
          pdsa_pkg::MSG_PS_RDY: if (rev_code == pdsa_pkg::SPEC_REV_30 && epr_req_seen) begin
            arm_countdown();
            expect_frame(KEEPALIVE_FRAME, 6);
          end
          default: ;
        endcase
      end else if (rev_code == pdsa_pkg::SPEC_REV_30) begin
        // Extended header: chunked bit 15, chunk number 14..11, request bit 10,
        // data size 8..0, taken from pay1:pay0
        if (mtype == pdsa_pkg::MSG_EPR_SRC_CAP && it.pay1[7] && !it.pay1[2]) begin
          if (it.pay1[6:3] == 4'd0) begin
            expect_frame(CHUNK_REQ_FRAME, 6);
          end else if (it.pay1[6:3] == 4'd1) begin
            epr_req_seen = 1'b1;
            expect_frame(EPR_REQ_FRAME, 10);
          end
        end else if (mtype == pdsa_pkg::MSG_EXT_CONTROL &&
                     {it.pay1[0], it.pay0} >= pdsa_pkg::EXT_SIZE_MIN &&
                     it.pay2 == pdsa_pkg::ECDB_KEEPALIVE_ACK) begin
          arm_countdown();
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic pdsa_pkg::pdsa_in_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(pdsa_pkg::pdsa_in_t)-1:0];
  endfunction

  // Well-formed SOP frame; bits that the block does not decode stay random
  function automatic pdsa_pkg::pdsa_in_t rx_frame(input logic [4:0] mtype, input logic ext,
                                                  input logic [7:0] p0, input logic [7:0] p1,
                                                  input logic [7:0] p2, input logic [7:0] p3);
    pdsa_pkg::pdsa_in_t it;
    it = random_item();
    it.kind         = 1'b0;
    it.is_sop0      = 1'b1;
    it.frame_len    = 6'($urandom_range(6, 63));
    it.hdr_lo[4:0]  = mtype;
    it.hdr_hi[7]    = ext;
    it.pay0         = p0;
    it.pay1         = p1;
    it.pay2         = p2;
    it.pay3         = p3;
    return it;
  endfunction

  function automatic pdsa_pkg::pdsa_in_t tick_item(input logic ready);
    pdsa_pkg::pdsa_in_t it;
    it = random_item();
    it.kind     = 1'b1;
    it.tx_ready = ready;
    return it;
  endfunction

  // Now and then spoil a frame: off SOP or too short
  function automatic pdsa_pkg::pdsa_in_t roughen(input pdsa_pkg::pdsa_in_t it);
    pdsa_pkg::pdsa_in_t r;
    r = it;
    case ($urandom_range(0, 11))
      0: r.is_sop0 = 1'b0;
      1: r.frame_len = 6'($urandom_range(0, 5));
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic void send(input pdsa_pkg::pdsa_in_t it);
    frames_to_send.push_back(it);
    queued_cnt++;
  endfunction

  // One random pick; the EPR handshake is sent as a whole sequence so that
  // the countdown and the KeepAlive path are reached often.
  function automatic void add_random_items();
    int unsigned        pick;
    pdsa_pkg::pdsa_in_t it;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send(tick_item($urandom_range(0, 4) != 0));
    end else if (pick < 30) begin
      send(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, rnd8(),
                    8'h80 | 8'($urandom_range(0, 3)), rnd8(), rnd8()));
      send(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, rnd8(),
                    8'h88 | 8'($urandom_range(0, 3)), rnd8(), rnd8()));
      send(rx_frame(pdsa_pkg::MSG_PS_RDY, 1'b0, rnd8(), rnd8(), rnd8(), rnd8()));
      repeat ($urandom_range(1, 4)) send(tick_item($urandom_range(0, 3) != 0));
    end else if (pick < 40) begin
      it = rx_frame(pdsa_pkg::MSG_SRC_CAP, 1'b0, rnd8(), rnd8(), rnd8(), rnd8());
      send(roughen(it));
    end else if (pick < 48) begin
      send(roughen(rx_frame(pdsa_pkg::MSG_GET_SINK_CAP, 1'b0, rnd8(), rnd8(), rnd8(),
                            rnd8())));
    end else if (pick < 51) begin
      send(roughen(rx_frame(pdsa_pkg::MSG_SOFT_RESET, 1'b0, rnd8(), rnd8(), rnd8(),
                            rnd8())));
    end else if (pick < 61) begin
      it = rx_frame(pdsa_pkg::MSG_EXT_CONTROL, 1'b1, rnd8(), rnd8(),
                    ($urandom_range(0, 3) != 0) ? pdsa_pkg::ECDB_KEEPALIVE_ACK : rnd8(),
                    rnd8());
      send(roughen(it));
    end else if (pick < 71) begin
      send(roughen(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, rnd8(), rnd8(), rnd8(),
                            rnd8())));
    end else if (pick < 76) begin
      send(roughen(rx_frame(pdsa_pkg::MSG_PS_RDY, 1'b0, rnd8(), rnd8(), rnd8(), rnd8())));
    end else begin
      // noise: mostly frames, every field random
      it = random_item();
      if ($urandom_range(0, 4) != 0) it.kind = 1'b0;
      send(it);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps; hold the item while full
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : drive_input
    logic               next_push;
    pdsa_pkg::pdsa_in_t next_item;
    next_push = push;
    next_item = in_data;
    if (rst_n && push && !full) begin
      predict_response(in_data);
      accepted_cnt++;
      next_push = 1'b0;
    end
    if (rst_n && !next_push) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (frames_to_send.size() != 0) begin
        next_item = frames_to_send.pop_front();
        next_push = 1'b1;
        if (burst_left <= 1) begin
          // new burst: sometimes long stretches with no idling at all
          burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
    push    <= next_push;
    in_data <= next_item;
  end

  // --------------------------------------------------------------------------
  // Monitor: check each popped byte, stall on a pattern that changes mode
  // --------------------------------------------------------------------------
  int unsigned pop_mode   = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;

  function automatic void flag_mismatch(input string what, input pdsa_pkg::pdsa_out_t want,
                                        input pdsa_pkg::pdsa_out_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch (%s): expected byte %h last %b, got byte %h last %b",
               what, want.out_byte, want.last, got.out_byte, got.last);
  endfunction

  always @(posedge clk) begin : take_results
    pdsa_pkg::pdsa_out_t want;
    if (rst_n && pop && !empty) begin
      if (bytes_due.size() == 0) begin
        flag_mismatch("no byte expected", '0, out_data);
      end else begin
        want = bytes_due.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.last !== want.last)
          flag_mismatch("response byte", want, out_data);
      end
    end
    // modes: always ready, single-cycle stalls, random stall runs
    if (mode_left == 0) begin
      pop_mode  = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (pop_mode == 1 && $urandom_range(0, 1) == 0) stall_left = 1;
      else if (pop_mode == 2 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    int unsigned cycles;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_pd_sink_auto_responder failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------

  // Wait until every item has transferred and every byte has been seen, then
  // give the block time to finish anything that produces no bytes.
  task automatic settle();
    while (accepted_cnt != queued_cnt || bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pdsa_pkg::CFG_PD_ENABLED: en_sink = value[0];
      pdsa_pkg::CFG_SPEC_REV:   rev_code = value[1:0];
      default:                  ka_period = value;
    endcase
  endtask

  // Write all three registers while idle, then step off the edge
  task automatic configure(input logic en, input logic [1:0] rev, input logic [15:0] period);
    settle();
    write_reg(pdsa_pkg::CFG_PD_ENABLED, {15'h0, en});
    write_reg(pdsa_pkg::CFG_SPEC_REV, {14'h0, rev});
    write_reg(pdsa_pkg::CFG_KA_PERIOD, period);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic en, input logic [1:0] rev, input logic [15:0] period,
                           input int unsigned n_items);
    int unsigned start;
    configure(en, rev, period);
    start = queued_cnt;
    while (queued_cnt - start < n_items) add_random_items();
  endtask

  initial begin : stimulus
    pdsa_pkg::pdsa_in_t it;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: sink disabled, so frames are dropped; ticks do nothing
    // while EPR mode is off.
    send(rx_frame(pdsa_pkg::MSG_GET_SINK_CAP, 1'b0, rnd8(), rnd8(), rnd8(), rnd8()));
    send(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, 8'h00, 8'h80, 8'h00, 8'h00));
    send(tick_item(1'b1));

    // Directed pass: PD 3.0, period of two ticks
    configure(1'b1, pdsa_pkg::SPEC_REV_30, 16'd2);
    send(rx_frame(pdsa_pkg::MSG_GET_SINK_CAP, 1'b0, rnd8(), rnd8(), rnd8(), rnd8()));
    it = rx_frame(pdsa_pkg::MSG_SRC_CAP, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    it.hdr_hi[6:4] = 3'd7;
    send(it);
    it = rx_frame(pdsa_pkg::MSG_SRC_CAP, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    it.hdr_hi[6:4] = 3'd1;
    send(it);
    it.hdr_hi[6:4] = 3'd0;                       // no data objects: dropped
    send(it);
    it = rx_frame(pdsa_pkg::MSG_GET_SINK_CAP, 1'b0, rnd8(), rnd8(), rnd8(), rnd8());
    it.frame_len = 6'd5;                         // too short
    send(it);
    it.frame_len = 6'd63;
    it.is_sop0   = 1'b0;                         // not SOP
    send(it);
    // no EPR request yet
    send(rx_frame(pdsa_pkg::MSG_PS_RDY, 1'b0, rnd8(), rnd8(), rnd8(), rnd8()));
    // chunk 0, request bit set, not chunked, chunk 2, chunk 1
    send(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, 8'h00, 8'h80, 8'h00, 8'h00));
    send(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, 8'h00, 8'h84, 8'h00, 8'h00));
    send(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, 8'h00, 8'h08, 8'h00, 8'h00));
    send(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, 8'h00, 8'h90, 8'h00, 8'h00));
    send(rx_frame(pdsa_pkg::MSG_EPR_SRC_CAP, 1'b1, 8'hFF, 8'h8B, 8'hFF, 8'hFF));
    // enter EPR mode
    send(rx_frame(pdsa_pkg::MSG_PS_RDY, 1'b0, rnd8(), rnd8(), rnd8(), rnd8()));
    send(tick_item(1'b1));
    send(tick_item(1'b1));                       // KeepAlive due
    send(tick_item(1'b0));
    send(tick_item(1'b0));                       // due but tx_ready low: pending
    send(tick_item(1'b1));                       // pending KeepAlive goes out
    send(rx_frame(pdsa_pkg::MSG_EXT_CONTROL, 1'b1, 8'h01, 8'h00,
                  pdsa_pkg::ECDB_KEEPALIVE_ACK, 8'h00));
    send(rx_frame(pdsa_pkg::MSG_EXT_CONTROL, 1'b1, 8'hFF, 8'hFF,
                  pdsa_pkg::ECDB_KEEPALIVE_ACK, 8'hFF));
    send(rx_frame(pdsa_pkg::MSG_EXT_CONTROL, 1'b1, 8'h02, 8'h00, 8'h03, 8'h00));
    send(rx_frame(pdsa_pkg::MSG_SOFT_RESET, 1'b0, rnd8(), rnd8(), rnd8(), rnd8()));
    send(tick_item(1'b1));                       // state cleared: nothing
    it = rx_frame(pdsa_pkg::MSG_GET_SINK_CAP, 1'b0, rnd8(), rnd8(), rnd8(), rnd8());
    it.hdr_lo    = 8'hE8;
    it.hdr_hi    = 8'h7F;
    it.frame_len = 6'd63;
    send(it);

    // Random phases across the register space, extremes included
    run_phase(1'b1, pdsa_pkg::SPEC_REV_30, 16'd3, 60);
    run_phase(1'b1, pdsa_pkg::SPEC_REV_30, 16'd0, 45);   // zero period: every ready tick
    run_phase(1'b1, 2'd2, 16'd5, 40);
    run_phase(1'b0, pdsa_pkg::SPEC_REV_30, 16'd2, 20);   // disabled: only ticks matter
    run_phase(1'b1, 2'd1, 16'd1, 35);
    run_phase(1'b1, 2'd0, 16'd4, 35);
    run_phase(1'b1, pdsa_pkg::SPEC_REV_30, 16'hFFFF, 40);
    run_phase(1'b1, pdsa_pkg::SPEC_REV_30, 16'd1, 65);
    settle();

    if (errors == 0) begin
      $display("tb_pd_sink_auto_responder passed");
    end else begin
      $display("tb_pd_sink_auto_responder failed");
    end
    $finish;
  end

endmodule
